[sv/sbk_pkg.sv]
// Shared types and constants for the sort-by-key and gap-energy block.
// Holds field widths, write-select codes and the controller/datapath structs.
// No dependencies.
package sbk_pkg;

    localparam int ID_W       = 8;
    localparam int POS_W      = 8;
    localparam int ENERGY_W   = 17;
    localparam int ACC_W      = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;

    localparam int ENERGY_MAX = 65535;
    localparam int ENERGY_MIN = -64;

    // store write source
    localparam logic [1:0] WSEL_IN  = 2'd0;
    localparam logic [1:0] WSEL_MIN = 2'd1;
    localparam logic [1:0] WSEL_A   = 2'd2;

    typedef struct packed {
        logic       mem_re;
        logic       mem_we;
        logic [1:0] wsel;
        logic       load_a;
        logic       cmp_en;
        logic       cost_en;
        logic       cost_first;
        logic       cost_last;
        logic       clear_cost;
        logic       finish_cost;
        logic       out_load;
        logic       out_last;
    } sbk_cmd_t;

    typedef struct packed {
        logic swap_needed;
        logic out_free;
    } sbk_stat_t;

endpackage

[sv/sbk_datapath.sv]
// Datapath: element store, minimum search registers, gap cost pipeline and
// output register. Driven by sbk_ctrl through sbk_cmd_t; depends on sbk_pkg.
module sbk_datapath
    import sbk_pkg::*;
#(
    parameter int MAX_LIST = 64,
    parameter int KEY_BITS = 8,
    localparam int IDX_W   = $clog2(MAX_LIST),
    localparam int CNT_W   = $clog2(MAX_LIST + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    input  logic [ID_W-1:0]      in_id,
    input  logic [POS_W-1:0]     in_pos,
    input  sbk_cmd_t             cmd,
    input  logic [IDX_W-1:0]     rd_addr,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [IDX_W-1:0]     cmp_idx,
    input  logic [CNT_W-1:0]     n_cnt,
    output sbk_stat_t            stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] sorted_id, [15:8] sorted_position,
                                            // [32:16] gap_energy, [39:33] zero
    output logic                 m_tlast    // last_out
);

    localparam int WORD_W = ID_W + KEY_BITS;
    localparam int G_W    = KEY_BITS + 2;
    localparam int SQ_W   = 2 * KEY_BITS + 1;
    localparam int SUM_W  = ((SQ_W > ACC_W) ? SQ_W : ACC_W) + 1;
    localparam int LIN_W  = ((KEY_BITS > CNT_W) ? KEY_BITS : CNT_W) + 2;

    logic [WORD_W-1:0]          mem [MAX_LIST];
    logic [WORD_W-1:0]          rdata_reg;
    logic [WORD_W-1:0]          a_word_reg;
    logic [WORD_W-1:0]          min_word_reg;
    logic [IDX_W-1:0]           min_idx_reg;
    logic                       energy_mode_reg;
    logic [KEY_BITS-1:0]        prev_key_reg;
    logic [KEY_BITS-1:0]        first_key_reg;
    logic [KEY_BITS-1:0]        last_key_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic                       sq_valid_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic signed [ENERGY_W-1:0] energy_reg;
    logic                       out_valid_reg;
    logic [ID_W-1:0]            out_id_reg;
    logic [POS_W-1:0]           out_pos_reg;
    logic                       out_last_reg;
    logic signed [ENERGY_W-1:0] out_energy_reg;

    logic [WORD_W-1:0]          wdata;
    logic [IDX_W-1:0]           waddr;
    logic [KEY_BITS-1:0]        in_key;
    logic [KEY_BITS-1:0]        rd_key;
    logic [KEY_BITS-1:0]        min_key;
    logic [15:0]                rd_key_ext;
    logic signed [G_W-1:0]      gap;
    logic signed [2*G_W-1:0]    gap_sq;
    logic [SUM_W-1:0]           acc_sum;
    logic [ACC_W-1:0]           acc_sat;
    logic signed [LIN_W-1:0]    lin;
    logic signed [ENERGY_W-1:0] lin_sat;

    assign in_key     = KEY_BITS'(in_pos);
    assign rd_key     = rdata_reg[KEY_BITS-1:0];
    assign min_key    = min_word_reg[KEY_BITS-1:0];
    assign rd_key_ext = 16'(rd_key);

    always_comb begin
        unique case (cmd.wsel)
            WSEL_MIN: begin
                wdata = min_word_reg;
                waddr = wr_addr;
            end
            WSEL_A: begin
                wdata = a_word_reg;
                waddr = min_idx_reg;
            end
            default: begin
                wdata = {in_id, in_key};
                waddr = wr_addr;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.mem_re) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // minimum search: strict less-than keeps the first minimum
    always_ff @(posedge aclk) begin
        if (cmd.load_a) begin
            a_word_reg   <= rdata_reg;
            min_word_reg <= rdata_reg;
            min_idx_reg  <= cmp_idx;
        end else if (cmd.cmp_en && (rd_key < min_key)) begin
            min_word_reg <= rdata_reg;
            min_idx_reg  <= cmp_idx;
        end
    end

    assign stat.swap_needed = a_word_reg[WORD_W-1 -: ID_W] != min_word_reg[WORD_W-1 -: ID_W];
    assign stat.out_free    = !out_valid_reg || m_tready;

    // gap cost: square in one stage, saturating accumulate in the next
    assign gap     = $signed(G_W'(rd_key)) - $signed(G_W'(prev_key_reg)) - $signed(G_W'(1));
    assign gap_sq  = gap * gap;
    assign acc_sum = SUM_W'(acc_reg) + SUM_W'(sq_reg);
    assign acc_sat = (acc_sum > SUM_W'(ENERGY_MAX)) ? ACC_W'(ENERGY_MAX) : acc_sum[ACC_W-1:0];

    assign lin = $signed(LIN_W'(last_key_reg)) - $signed(LIN_W'(first_key_reg))
               - $signed(LIN_W'(n_cnt - CNT_W'(1)));

    always_comb begin
        if (lin < ENERGY_MIN) begin
            lin_sat = ENERGY_W'(ENERGY_MIN);
        end else if (lin > ENERGY_MAX) begin
            lin_sat = ENERGY_W'(ENERGY_MAX);
        end else begin
            lin_sat = ENERGY_W'(lin);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cost_en) begin
            prev_key_reg <= rd_key;
            sq_reg       <= gap_sq[SQ_W-1:0];
            if (cmd.cost_first) begin
                first_key_reg <= rd_key;
            end
            if (cmd.cost_last) begin
                last_key_reg <= rd_key;
            end
        end
        if (cmd.finish_cost) begin
            energy_reg <= energy_mode_reg ? $signed({1'b0, acc_reg}) : lin_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg    <= 1'b0;
            acc_reg         <= '0;
            energy_mode_reg <= 1'b1;
        end else begin
            if (cfg_valid) begin
                energy_mode_reg <= cfg_data;
            end
            if (cmd.clear_cost) begin
                sq_valid_reg <= 1'b0;
                acc_reg      <= '0;
            end else begin
                sq_valid_reg <= cmd.cost_en && !cmd.cost_first;
                if (sq_valid_reg) begin
                    acc_reg <= acc_sat;
                end
            end
        end
    end

    // output register: hold the word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_id_reg     <= rdata_reg[WORD_W-1 -: ID_W];
            out_pos_reg    <= rd_key_ext[POS_W-1:0];
            out_last_reg   <= cmd.out_last;
            out_energy_reg <= cmd.out_last ? energy_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(M_TDATA_W - ENERGY_W - POS_W - ID_W)'(0),
                       out_energy_reg, out_pos_reg, out_id_reg};

endmodule

[sv/sbk_ctrl.sv]
// Controller: load, selection sort passes, cost sweep and emission sequencing.
// Issues sbk_cmd_t to sbk_datapath and reads sbk_stat_t; depends on sbk_pkg.
module sbk_ctrl
    import sbk_pkg::*;
#(
    parameter int MAX_LIST = 64,
    localparam int IDX_W   = $clog2(MAX_LIST),
    localparam int CNT_W   = $clog2(MAX_LIST + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_tlast,
    output sbk_cmd_t         cmd,
    output logic [IDX_W-1:0] rd_addr,
    output logic [IDX_W-1:0] wr_addr,
    output logic [IDX_W-1:0] cmp_idx,
    output logic [CNT_W-1:0] n_cnt,
    input  sbk_stat_t        stat
);

    localparam logic [3:0] ST_LOAD      = 4'd0;
    localparam logic [3:0] ST_PASS      = 4'd1;
    localparam logic [3:0] ST_PASS_A    = 4'd2;
    localparam logic [3:0] ST_SCAN      = 4'd3;
    localparam logic [3:0] ST_SWAP      = 4'd4;
    localparam logic [3:0] ST_SWAP2     = 4'd5;
    localparam logic [3:0] ST_COST_RD   = 4'd6;
    localparam logic [3:0] ST_COST      = 4'd7;
    localparam logic [3:0] ST_COST_WAIT = 4'd8;
    localparam logic [3:0] ST_COST_DONE = 4'd9;
    localparam logic [3:0] ST_EMIT_RD   = 4'd10;
    localparam logic [3:0] ST_EMIT_LD   = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] a_reg, a_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic [IDX_W-1:0] e_reg, e_next;

    logic             accept;
    logic             has_room;
    logic [CNT_W-1:0] b_prev;
    logic [CNT_W:0]   a_plus2;
    logic             sort_more;
    logic             e_last;

    assign s_tready  = (state_reg == ST_LOAD);
    assign accept    = s_tvalid && s_tready;
    assign has_room  = fill_reg < CNT_W'(MAX_LIST);
    assign b_prev    = b_reg - CNT_W'(1);
    assign a_plus2   = (CNT_W + 1)'(a_reg) + (CNT_W + 1)'(2);
    assign sort_more = a_plus2 < {1'b0, n_reg};
    assign e_last    = (CNT_W'(e_reg) + CNT_W'(1)) == n_reg;
    assign n_cnt     = n_reg;

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        n_next     = n_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        e_next     = e_reg;
        cmd        = '0;
        cmd.wsel   = WSEL_IN;
        rd_addr    = b_reg[IDX_W-1:0];
        wr_addr    = a_reg;
        cmp_idx    = b_prev[IDX_W-1:0];

        unique case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    // drop the word when the store is full
                    if (has_room) begin
                        cmd.mem_we = 1'b1;
                        wr_addr    = fill_reg[IDX_W-1:0];
                        fill_next  = fill_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        cmd.clear_cost = 1'b1;
                        n_next         = has_room ? fill_reg + CNT_W'(1) : fill_reg;
                        fill_next      = '0;
                        a_next         = '0;
                        state_next     = (n_next < CNT_W'(2)) ? ST_COST_RD : ST_PASS;
                    end
                end
            end
            ST_PASS: begin
                cmd.mem_re = 1'b1;
                rd_addr    = a_reg;
                b_next     = CNT_W'(a_reg) + CNT_W'(1);
                state_next = ST_PASS_A;
            end
            ST_PASS_A: begin
                cmd.load_a = 1'b1;
                cmp_idx    = a_reg;
                cmd.mem_re = 1'b1;
                b_next     = b_reg + CNT_W'(1);
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.cmp_en = 1'b1;
                if (b_reg < n_reg) begin
                    cmd.mem_re = 1'b1;
                    b_next     = b_reg + CNT_W'(1);
                end else begin
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP: begin
                if (stat.swap_needed) begin
                    cmd.mem_we = 1'b1;
                    cmd.wsel   = WSEL_MIN;
                    state_next = ST_SWAP2;
                end else begin
                    a_next     = a_reg + IDX_W'(1);
                    state_next = sort_more ? ST_PASS : ST_COST_RD;
                end
            end
            ST_SWAP2: begin
                cmd.mem_we = 1'b1;
                cmd.wsel   = WSEL_A;
                a_next     = a_reg + IDX_W'(1);
                state_next = sort_more ? ST_PASS : ST_COST_RD;
            end
            ST_COST_RD: begin
                cmd.mem_re = 1'b1;
                rd_addr    = '0;
                b_next     = CNT_W'(1);
                state_next = ST_COST;
            end
            ST_COST: begin
                cmd.cost_en    = 1'b1;
                cmd.cost_first = (b_reg == CNT_W'(1));
                cmd.cost_last  = (b_reg == n_reg);
                if (b_reg < n_reg) begin
                    cmd.mem_re = 1'b1;
                    b_next     = b_reg + CNT_W'(1);
                end else begin
                    state_next = ST_COST_WAIT;
                end
            end
            ST_COST_WAIT: begin
                state_next = ST_COST_DONE;
            end
            ST_COST_DONE: begin
                cmd.finish_cost = 1'b1;
                e_next          = '0;
                state_next      = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                cmd.mem_re = 1'b1;
                rd_addr    = e_reg;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = e_last;
                    if (e_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        e_next     = e_reg + IDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            fill_reg  <= '0;
            n_reg     <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            e_reg     <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            n_reg     <= n_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            e_reg     <= e_next;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(MAX_LIST))
        else $error("fill count beyond store depth");

    a_swap_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWAP2) |-> ($past(state_reg) == ST_SWAP && $past(stat.swap_needed)))
        else $error("second swap write without first");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten while held");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (CNT_W'(a_reg) < n_reg && b_reg <= n_reg))
        else $error("scan outside stored list");

endmodule

[sv/sort_by_key_and_gap_energy.sv]
// Throughput: one input word per cycle while loading. After the word with tlast,
// the list is sorted by selection sort passes (the minimum and the pass head are
// written back on an exchange), then swept once for the gap cost, then emitted one
// result word at a time; all reads go through the single read port of the element
// store. Results wait in an output register. Reset (aresetn low, synchronous)
// clears control state and sets energy_mode to 1; the element store is not cleared.
module sort_by_key_and_gap_energy
    import sbk_pkg::*;
#(
    parameter int MAX_LIST = 64,
    parameter int KEY_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] prey_id, [15:8] prey_position
    input  logic                 s_tlast,   // last_in
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] sorted_id, [15:8] sorted_position,
                                            // [32:16] gap_energy, [39:33] zero
    output logic                 m_tlast,   // last_out
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data   // energy_mode
);

    localparam int IDX_W = $clog2(MAX_LIST);
    localparam int CNT_W = $clog2(MAX_LIST + 1);

    sbk_cmd_t         cmd;
    sbk_stat_t        stat;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] cmp_idx;
    logic [CNT_W-1:0] n_cnt;

    assign cfg_ready = 1'b1;

    sbk_ctrl #(
        .MAX_LIST (MAX_LIST)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .cmp_idx  (cmp_idx),
        .n_cnt    (n_cnt),
        .stat     (stat)
    );

    sbk_datapath #(
        .MAX_LIST (MAX_LIST),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .in_id     (s_tdata[ID_W-1:0]),
        .in_pos    (s_tdata[ID_W +: POS_W]),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .cmp_idx   (cmp_idx),
        .n_cnt     (n_cnt),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[bench/sorted_list_checker.sv]
`timescale 1ns / 100ps
// Watches the element, result and mode-write channels of sort_by_key_and_gap_energy,
// predicts each sorted list with its gap cost and compares every result word.
// Depends on sbk_pkg for the channel widths and the cost limits.
module sorted_list_checker
    import sbk_pkg::*;
#(
    parameter int MAX_LIST = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] prey_id, [15:8] prey_position
    input  logic                 s_tlast,   // last_in
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [7:0] sorted_id, [15:8] sorted_position,
                                            // [32:16] gap_energy, [39:33] zero
    input  logic                 m_tlast,   // last_out
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_data,  // energy_mode
    output int                   fail_count,
    output int                   words_due
);

    typedef struct packed {
        logic [ID_W-1:0]            id;
        logic [POS_W-1:0]           pos;
        logic                       last;
        logic signed [ENERGY_W-1:0] energy;
    } sorted_word_t;

    sorted_word_t     expected_words[$];
    logic [ID_W-1:0]  held_id[MAX_LIST];
    logic [POS_W-1:0] held_key[MAX_LIST];
    int               held_count;
    logic             squared_mode;

    // first minimum wins; exchange only when the identifiers differ
    task automatic sort_held_list();
        int               m;
        logic [ID_W-1:0]  tmp_id;
        logic [POS_W-1:0] tmp_key;
        for (int a = 0; a + 1 < held_count; a++) begin
            m = a;
            for (int b = a + 1; b < held_count; b++) begin
                if (held_key[b] < held_key[m]) m = b;
            end
            if (held_id[m] != held_id[a]) begin
                tmp_id      = held_id[a];
                tmp_key     = held_key[a];
                held_id[a]  = held_id[m];
                held_key[a] = held_key[m];
                held_id[m]  = tmp_id;
                held_key[m] = tmp_key;
            end
        end
    endtask

    // cost is taken from the emitted order, which need not be ascending
    function automatic int held_gap_cost();
        int cost;
        int step;
        cost = 0;
        if (held_count < 2) return 0;
        if (!squared_mode) begin
            cost = int'(held_key[held_count - 1]) - int'(held_key[0]) - (held_count - 1);
        end else begin
            for (int i = 0; i + 1 < held_count; i++) begin
                step = int'(held_key[i + 1]) - int'(held_key[i]) - 1;
                cost += step * step;
            end
        end
        if (cost < ENERGY_MIN) cost = ENERGY_MIN;
        if (cost > ENERGY_MAX) cost = ENERGY_MAX;
        return cost;
    endfunction

    task automatic take_element(input logic [ID_W-1:0] id, input logic [POS_W-1:0] key,
                                input logic last);
        int           cost;
        sorted_word_t w;
        // drop elements once the store is full
        if (held_count < MAX_LIST) begin
            held_id[held_count]  = id;
            held_key[held_count] = key;
            held_count++;
        end
        if (last) begin
            sort_held_list();
            cost = held_gap_cost();
            for (int i = 0; i < held_count; i++) begin
                w.id     = held_id[i];
                w.pos    = held_key[i];
                w.last   = (i == held_count - 1);
                w.energy = w.last ? cost[ENERGY_W-1:0] : '0;
                expected_words = {expected_words, w};
            end
            held_count = 0;
        end
    endtask

    task automatic check_word();
        sorted_word_t got;
        sorted_word_t want;
        got.id     = m_tdata[ID_W-1:0];
        got.pos    = m_tdata[ID_W +: POS_W];
        got.energy = m_tdata[ID_W + POS_W +: ENERGY_W];
        got.last   = m_tlast;
        if (expected_words.size() == 0) begin
            $display("%0t: result word with none expected: id %0d pos %0d last %0b energy %0d",
                     $time, got.id, got.pos, got.last, $signed(got.energy));
            fail_count++;
            return;
        end
        want = expected_words.pop_front();
        if (got.id !== want.id) begin
            $display("%0t: sorted_id expected %0d actual %0d", $time, want.id, got.id);
            fail_count++;
        end
        if (got.pos !== want.pos) begin
            $display("%0t: sorted_position expected %0d actual %0d", $time, want.pos, got.pos);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $display("%0t: last_out expected %0b actual %0b", $time, want.last, got.last);
            fail_count++;
        end
        if (got.energy !== want.energy) begin
            $display("%0t: gap_energy expected %0d actual %0d", $time,
                     $signed(want.energy), $signed(got.energy));
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_words.delete();
            held_count   = 0;
            squared_mode = 1'b1;
            fail_count   = 0;
        end else begin
            if (cfg_valid && cfg_ready) squared_mode = cfg_data;
            if (m_tvalid && m_tready) check_word();
            if (s_tvalid && s_tready)
                take_element(s_tdata[ID_W-1:0], s_tdata[ID_W +: POS_W], s_tlast);
        end
        words_due = expected_words.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for sort_by_key_and_gap_energy: directed lists, then random
// lists with mode changes, random idling and a long result hold-off.
// Depends on sbk_pkg, the block itself and sorted_list_checker.
module tb;
    import sbk_pkg::*;

    localparam int   LIST_DEPTH     = 64;
    localparam int   RANDOM_WORDS   = 265;
    localparam int   HOLD_CYCLES    = 400;
    localparam int   SETTLE_CYCLES  = 16;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam logic MODE_LINEAR    = 1'b0;
    localparam logic MODE_SQUARED   = 1'b1;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [7:0] prey_id, [15:8] prey_position
    logic                 s_tlast;   // last_in
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [7:0] sorted_id, [15:8] sorted_position,
                                     // [32:16] gap_energy, [39:33] zero
    logic                 m_tlast;   // last_out
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;  // energy_mode

    int   fail_count;
    int   words_due;
    int   words_sent   = 0;
    int   quiet_cycles = 0;
    logic calm         = 1'b0;
    logic hold_req     = 1'b0;

    sort_by_key_and_gap_energy #(
        .MAX_LIST(LIST_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    sorted_list_checker #(
        .MAX_LIST(LIST_DEPTH)
    ) list_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .words_due (words_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        logic held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 28);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [ID_W-1:0] id, input logic [POS_W-1:0] key,
                             input logic last);
        while (!calm && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {key, id};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // drop valid, then hold until every expected word has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (words_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_list(input int len);
        logic             twin_ids;
        logic             close_keys;
        logic [ID_W-1:0]  id_base;
        logic [POS_W-1:0] key_base;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] key;
        twin_ids   = ($urandom_range(0, 3) == 0);
        close_keys = ($urandom_range(0, 3) == 0);
        id_base    = ID_W'($urandom_range(0, 255));
        key_base   = POS_W'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
            // narrow pools give repeated identifiers and tied keys
            if (twin_ids) id = id_base + ID_W'($urandom_range(0, 1));
            else          id = ID_W'($urandom_range(0, 255));
            if (close_keys) key = key_base + POS_W'($urandom_range(0, 3));
            else            key = POS_W'($urandom_range(0, 255));
            send_word(id, key, i == len - 1);
        end
        words_sent += len;
    endtask

    initial begin
        int list_no;
        int len;
        int pick;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single element, all ones
        send_word(8'hFF, 8'hFF, 1'b1);
        // two elements out of order, widest gap
        send_word(8'h00, 8'hFF, 1'b0);
        send_word(8'hFF, 8'h00, 1'b1);
        // one identifier throughout: no exchange, squared cost saturates high
        send_word(8'h5A, 8'hFF, 1'b0);
        send_word(8'h5A, 8'h00, 1'b0);
        send_word(8'h5A, 8'hFF, 1'b1);
        // tied keys: first minimum kept
        send_word(8'h01, 8'h0A, 1'b0);
        send_word(8'h02, 8'h05, 1'b0);
        send_word(8'h03, 8'h05, 1'b0);
        send_word(8'h00, 8'h00, 1'b1);
        write_mode(MODE_LINEAR);
        // descending keys under one identifier: linear cost saturates low
        send_word(8'h09, 8'hFF, 1'b0);
        send_word(8'h09, 8'h00, 1'b1);
        send_word(8'hAA, 8'hC8, 1'b0);
        send_word(8'h55, 8'h03, 1'b0);
        send_word(8'h0F, 8'h64, 1'b1);
        write_mode(MODE_SQUARED);

        list_no = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (list_no % 6 == 5) write_mode(1'($urandom_range(0, 1)));
            calm = (list_no >= 10 && list_no < 17);
            if (list_no == 7) hold_req = 1'b1;
            if (list_no == 3) begin
                len = LIST_DEPTH;
            end else if (list_no == 12) begin
                len = LIST_DEPTH + 2;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 15)      len = 1;
                else if (pick < 70) len = $urandom_range(2, 6);
                else                len = $urandom_range(7, 12);
            end
            send_list(len);
            list_no++;
        end

        wait_for_results();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
